/* src/tcwc_pkg.sv */
// Package for the congestion window controller: word types, command and
// mode codes, register indexes and reset constants. No dependencies.
package tcwc_pkg;

	localparam int NUM_PEERS_DEF  = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int PEER_W         = 4;

	localparam logic [1:0] CMD_ACK     = 2'd0;
	localparam logic [1:0] CMD_TIMEOUT = 2'd1;
	localparam logic [1:0] CMD_SEND    = 2'd2;

	localparam logic [1:0] MODE_SS = 2'd0;
	localparam logic [1:0] MODE_AI = 2'd1;
	localparam logic [1:0] MODE_FR = 2'd2;

	localparam logic REG_WINDOW_SIZE = 1'b0;
	localparam logic REG_INIT_THRESH = 1'b1;

	localparam logic [6:0] WINDOW_SIZE_RST = 7'd8;
	localparam logic [7:0] INIT_THRESH_RST = 8'd64;
	localparam logic [7:0] DUP_TRIGGER     = 8'd3;
	localparam logic [7:0] DUP_MAX         = 8'd255;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] peer;
		logic [7:0] ack_number;
		logic       is_retransmit;
	} in_word_t;

	typedef struct packed {
		logic [6:0] newly_acked;
		logic       fast_retransmit;
		logic [7:0] retransmit_sequence;
		logic       send_granted;
		logic [7:0] assigned_sequence;
		logic [7:0] window_whole;
		logic [1:0] control_mode;
	} out_word_t;

endpackage

/* src/tcwc_div.sv */
// Radix-2 restoring divider computing floor(2^(2F) / divisor), one quotient
// bit per cycle. Depends on tcwc_pkg for the default FRAC_BITS; no instances.
module tcwc_div import tcwc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [FRAC_BITS+7:0]     divisor,
	output logic                     done,
	output logic [2*FRAC_BITS:0]     quot
);
	localparam int DW = FRAC_BITS + 8;
	localparam int QW = 2 * FRAC_BITS + 1;
	localparam int CNT_W = $clog2(QW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW-1:0]    divisor_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    quot_q;
	logic             first_q;

	logic [DW:0] shifted;
	logic [DW:0] diff;
	logic        qbit;

	// dividend is a single one followed by zeros
	assign shifted = {rem_q, first_q};
	assign diff    = shifted - {1'b0, divisor_q};
	assign qbit    = (shifted >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quot_q    <= '0;
			first_q   <= 1'b1;
		end else if (cnt_q != '0) begin
			rem_q   <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
			quot_q  <= {quot_q[QW-2:0], qbit};
			first_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* src/tcwc_peer_mem.sv */
// Per-peer state memory with one valid bit per entry; an entry never
// written reads as the reset record. Depends on tcwc_pkg.
module tcwc_peer_mem import tcwc_pkg::*; #(
	parameter int               DEPTH   = NUM_PEERS_DEF,
	parameter int               WIDTH   = 8,
	parameter int               AW      = 4,
	parameter logic [WIDTH-1:0] RST_VAL = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvalid_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : RST_VAL;

endmodule

/* src/tcp_style_congestion_window_controller_top.sv */
// Top level of the Reno-style congestion window controller: sequencer,
// per-peer memory and shared divider. Depends on tcwc_pkg, tcwc_div, tcwc_peer_mem.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | in_word (cmd, peer, ack_number, ...)
//  out     | output    | out_valid/out_stall| out_word (newly_acked ... control_mode)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Timeout, send, duplicate ack and slow start words pass the load, execute and
// finish states before out_valid rises; in_stall holds the next word off until the
// sequencer is back in idle. An ack in additive increase adds the divide state
// after execute: the single divider yields one quotient bit a cycle and
// runs once per newly acked frame. No clearing pass after reset; per-peer valid bits stand
// for the reset record. A stalled result holds the write-back of the next word
// until it is taken.
module tcp_style_congestion_window_controller_top import tcwc_pkg::*; #(
	parameter int NUM_PEERS     = NUM_PEERS_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int F     = FRACTION_BITS;
	localparam int CW_W  = F + 8;
	localparam int QW    = 2 * F + 1;
	localparam int AW    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
	localparam int EXT_W = PEER_W + AW;
	localparam int REC_W = 2 * CW_W + 26;

	localparam logic [CW_W-1:0] CW_ONE = CW_W'(1) << F;
	localparam logic [CW_W-1:0] CW_TWO = CW_W'(2) << F;
	localparam logic [CW_W-1:0] CW_THREE = CW_W'(3) << F;
	localparam logic [CW_W-1:0] CW_MAX = '1;
	localparam logic [CW_W-1:0] SS_RST = CW_W'(INIT_THRESH_RST) << F;
	localparam logic [REC_W-1:0] REC_RST = {CW_ONE, SS_RST, 8'd0, MODE_SS, 8'd0, 8'd0};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	function automatic logic [CW_W-1:0] sat_cw(input logic [CW_W:0] s);
		return s[CW_W] ? CW_MAX : s[CW_W-1:0];
	endfunction

	function automatic logic [CW_W-1:0] half_floor(input logic [CW_W-1:0] cw);
		logic [CW_W-1:0] h;
		h = cw >> 1;
		return (h < CW_TWO) ? CW_TWO : h;
	endfunction

	logic [2:0]      state_q;
	logic [6:0]      window_size_q;
	in_word_t        item_q;
	logic            peer_ok_q;
	logic [AW-1:0]   addr_q;
	logic            out_valid_q;
	out_word_t       out_q;

	logic [CW_W-1:0] cw_q, ss_q;
	logic [7:0]      dup_q, base_q, nxt_q;
	logic [1:0]      mode_q;
	logic [6:0]      cnt_q;

	logic [6:0]      res_newly_q;
	logic            res_fr_q, res_grant_q;
	logic [7:0]      res_frseq_q, res_aseq_q;

	logic            accept, slot_free, fin_go;
	logic [EXT_W-1:0] peer_ext;
	logic [REC_W-1:0] rd_rec;

	logic            div_start, div_done;
	logic [CW_W-1:0] div_divisor, cw_div_sum;
	logic [QW-1:0]   quot;
	logic [QW:0]     quot_sum;

	// decisions made in the execute state
	logic [CW_W-1:0] n_cw, n_ss;
	logic [7:0]      n_dup, n_base, n_nxt;
	logic [1:0]      n_mode;
	logic [6:0]      n_newly;
	logic            n_fr, n_grant, go_div;
	logic [7:0]      n_frseq, n_aseq;

	logic [7:0]      ack_gap, fl, inflight, lim, dup_inc;
	logic [CW_W-1:0] ss_half, cw_ss;

	assign peer_ext  = {AW'(0), in_word.peer};
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign fin_go    = (state_q == ST_FIN) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE: window_size_q <= cfg_data[6:0];
				// the threshold only seeds peers at reset, and that value is fixed
				REG_INIT_THRESH: ;
				default: ;
			endcase
		end
	end

	tcwc_peer_mem #(
		.DEPTH   (NUM_PEERS),
		.WIDTH   (REC_W),
		.AW      (AW),
		.RST_VAL (REC_RST)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (fin_go && peer_ok_q),
		.waddr  (addr_q),
		.wdata  ({cw_q, ss_q, dup_q, mode_q, base_q, nxt_q}),
		.re     (accept),
		.raddr  (peer_ext[AW-1:0]),
		.rdata  (rd_rec)
	);

	assign quot_sum    = {1'b0, quot} + {(QW+1-CW_W)'(0), cw_q};
	assign cw_div_sum  = (quot_sum[QW:CW_W] != '0) ? CW_MAX : quot_sum[CW_W-1:0];
	assign div_divisor = (state_q == ST_DIV) ? cw_div_sum : cw_q;
	assign div_start   = ((state_q == ST_EXEC) && go_div) ||
	                     ((state_q == ST_DIV) && div_done && (cnt_q != 7'd1));

	tcwc_div #(.FRAC_BITS(F)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (quot)
	);

	always_comb begin
		n_cw = cw_q;   n_ss = ss_q;   n_dup = dup_q;
		n_base = base_q; n_nxt = nxt_q; n_mode = mode_q;
		n_newly = '0;  n_fr = 1'b0;   n_frseq = '0;
		n_grant = 1'b0; n_aseq = '0;  go_div = 1'b0;
		ack_gap  = item_q.ack_number - base_q;
		fl       = nxt_q - base_q;
		inflight = fl[7] ? 8'd0 : fl;
		lim      = (cw_q[F +: 8] == 8'd0) ? 8'd1 : cw_q[F +: 8];
		dup_inc  = (dup_q == DUP_MAX) ? DUP_MAX : dup_q + 8'd1;
		ss_half  = half_floor(cw_q);
		cw_ss    = sat_cw({1'b0, cw_q} + {1'b0, CW_W'(ack_gap[6:0]) << F});
		unique case (item_q.cmd)
			CMD_ACK: begin
				if (ack_gap == 8'd0) begin
					n_dup = dup_inc;
					if (dup_inc == DUP_TRIGGER) begin
						n_ss    = ss_half;
						n_cw    = sat_cw({1'b0, ss_half} + {1'b0, CW_THREE});
						n_mode  = MODE_FR;
						n_fr    = 1'b1;
						n_frseq = base_q;
					end else if (mode_q == MODE_FR) begin
						n_cw = sat_cw({1'b0, cw_q} + {1'b0, CW_ONE});
					end
				end else if (!ack_gap[7]) begin
					n_newly = ack_gap[6:0];
					n_base  = item_q.ack_number;
					n_dup   = '0;
					if (mode_q == MODE_FR) begin
						n_cw   = ss_q;
						n_mode = MODE_AI;
					end else if (cw_q <= ss_q) begin
						n_cw   = cw_ss;
						n_mode = (cw_ss > ss_q) ? MODE_AI : MODE_SS;
					end else begin
						// one divide per acked frame, each on the grown window
						go_div = 1'b1;
					end
				end
			end
			CMD_TIMEOUT: begin
				n_ss   = ss_half;
				n_cw   = CW_ONE;
				n_dup  = '0;
				n_mode = MODE_SS;
			end
			CMD_SEND: begin
				if (item_q.is_retransmit) begin
					n_grant = (inflight < lim);
				end else if ((inflight < {1'b0, window_size_q}) && (inflight < lim)) begin
					n_grant = 1'b1;
					n_aseq  = nxt_q;
					n_nxt   = nxt_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_EXEC;
				ST_EXEC: state_q <= go_div ? ST_DIV : ST_FIN;
				ST_DIV:  if (div_done && (cnt_q == 7'd1)) state_q <= ST_FIN;
				ST_FIN:  if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= in_word;
			addr_q    <= peer_ext[AW-1:0];
			peer_ok_q <= (peer_ext < EXT_W'(NUM_PEERS));
		end
		if (state_q == ST_LOAD)
			{cw_q, ss_q, dup_q, mode_q, base_q, nxt_q} <= rd_rec;
		if (state_q == ST_EXEC) begin
			cw_q <= n_cw; ss_q <= n_ss; dup_q <= n_dup;
			mode_q <= n_mode; base_q <= n_base; nxt_q <= n_nxt;
			res_newly_q <= n_newly; res_fr_q <= n_fr; res_frseq_q <= n_frseq;
			res_grant_q <= n_grant; res_aseq_q <= n_aseq;
			cnt_q <= n_newly;
		end
		if ((state_q == ST_DIV) && div_done) begin
			cw_q  <= cw_div_sum;
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				mode_q <= MODE_AI;
		end
		if (fin_go) begin
			if (peer_ok_q) begin
				out_q.newly_acked         <= res_newly_q;
				out_q.fast_retransmit     <= res_fr_q;
				out_q.retransmit_sequence <= res_frseq_q;
				out_q.send_granted        <= res_grant_q;
				out_q.assigned_sequence   <= res_aseq_q;
				out_q.window_whole        <= cw_q[F +: 8];
				out_q.control_mode        <= mode_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD))
		else $error("accepted word did not start a memory read");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_fr_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.fast_retransmit) |-> (out_word.control_mode == MODE_FR))
		else $error("fast retransmit without fast recovery mode");

	a_grant_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.send_granted) |->
		((out_word.newly_acked == 7'd0) && !out_word.fast_retransmit))
		else $error("send grant mixed with ack results");

endmodule
